// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition a implies condition b in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, a, b)

`endif

`endif

// ===== rtl/btps_pkg.sv =====
package btps_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // Pattern codes with special handling
  localparam logic [3:0] PAT_CONTINUOUS = 4'd9;
  localparam logic [3:0] PAT_SIREN      = 4'd10;

  // Note codes
  localparam logic [3:0] NOTE_SILENT = 4'd0;
  localparam logic [3:0] NOTE_C4     = 4'd1;
  localparam logic [3:0] NOTE_G4     = 4'd2;
  localparam logic [3:0] NOTE_C5     = 4'd3;
  localparam logic [3:0] NOTE_E5     = 4'd4;
  localparam logic [3:0] NOTE_G5     = 4'd5;
  localparam logic [3:0] NOTE_C6     = 4'd6;
  localparam logic [3:0] NOTE_LOW    = 4'd7;
  localparam logic [3:0] NOTE_MEDIUM = 4'd8;
  localparam logic [3:0] NOTE_HIGH   = 4'd9;

  localparam logic [2:0] MAX_NOTES = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_VERY_SHORT = 3'd0;
  localparam logic [2:0] REG_SHORT      = 3'd1;
  localparam logic [2:0] REG_PAUSE      = 3'd2;
  localparam logic [2:0] REG_MEDIUM     = 3'd3;
  localparam logic [2:0] REG_LONG       = 3'd4;
  localparam logic [2:0] REG_VERY_LONG  = 3'd5;
  localparam logic [2:0] REG_SIREN      = 3'd6;
  localparam logic [2:0] REG_CONT       = 3'd7;

  // Which step time a note uses
  typedef enum logic [2:0] {
    SEL_VS, SEL_S, SEL_P, SEL_M, SEL_L, SEL_VL
  } time_sel_t;

  typedef struct packed {
    logic [15:0] very_short_ms;
    logic [15:0] short_ms;
    logic [15:0] pause_short_ms;
    logic [15:0] medium_ms;
    logic [15:0] long_ms;
    logic [15:0] very_long_ms;
    logic [15:0] siren_interval_ms;
    logic [3:0]  continuous_note;
  } cfg_t;

  typedef struct packed {
    logic [2:0] step;
    logic       active;
    logic [3:0] note;
  } result_t;

  // Number of notes of a stepped pattern
  function automatic logic [2:0] seq_len(input logic [3:0] pat);
    logic [2:0] n;
    case (pat)
      4'd0:    n = 3'd1;
      4'd1:    n = 3'd3;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd4;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd3;
      4'd7:    n = 3'd4;
      4'd8:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Note sounded at a given position of a stepped pattern
  function automatic logic [3:0] seq_note(input logic [3:0] pat, input logic [1:0] idx);
    logic [3:0] nt;
    nt = NOTE_SILENT;
    case (pat)
      4'd0: if (idx == 2'd0) nt = NOTE_E5;
      4'd1: begin
        case (idx)
          2'd0:    nt = NOTE_C5;
          2'd2:    nt = NOTE_E5;
          default: nt = NOTE_SILENT;
        endcase
      end
      4'd2: begin
        case (idx)
          2'd0:    nt = NOTE_C5;
          2'd1:    nt = NOTE_E5;
          default: nt = NOTE_SILENT;
        endcase
      end
      4'd3: begin
        case (idx)
          2'd0:    nt = NOTE_C5;
          2'd1:    nt = NOTE_E5;
          2'd2:    nt = NOTE_G5;
          default: nt = NOTE_SILENT;
        endcase
      end
      4'd4: begin
        case (idx)
          2'd0:    nt = NOTE_C5;
          2'd1:    nt = NOTE_E5;
          2'd2:    nt = NOTE_G5;
          default: nt = NOTE_C6;
        endcase
      end
      4'd5: if (idx == 2'd0) nt = NOTE_LOW;
      4'd6: begin
        case (idx)
          2'd0:    nt = NOTE_HIGH;
          2'd1:    nt = NOTE_MEDIUM;
          2'd2:    nt = NOTE_LOW;
          default: nt = NOTE_SILENT;
        endcase
      end
      4'd7: begin
        case (idx)
          2'd0:    nt = NOTE_E5;
          2'd1:    nt = NOTE_C5;
          2'd2:    nt = NOTE_G4;
          default: nt = NOTE_C4;
        endcase
      end
      4'd8: begin
        case (idx)
          2'd0:    nt = NOTE_G4;
          2'd1:    nt = NOTE_C5;
          default: nt = NOTE_SILENT;
        endcase
      end
      default: nt = NOTE_SILENT;
    endcase
    return nt;
  endfunction

  // Step time used while a given note sounds
  function automatic time_sel_t seq_time(input logic [3:0] pat, input logic [1:0] idx);
    time_sel_t ts;
    ts = SEL_VS;
    case (pat)
      4'd1: begin
        case (idx)
          2'd1:    ts = SEL_P;
          2'd3:    ts = SEL_VS;
          default: ts = SEL_S;
        endcase
      end
      4'd2, 4'd8: ts = (idx == 2'd1) ? SEL_S : SEL_VS;
      4'd3: begin
        case (idx)
          2'd2:    ts = SEL_L;
          2'd3:    ts = SEL_VS;
          default: ts = SEL_M;
        endcase
      end
      4'd4, 4'd7: ts = (idx == 2'd3) ? SEL_VL : SEL_M;
      4'd6: begin
        case (idx)
          2'd2:    ts = SEL_M;
          default: ts = SEL_VS;
        endcase
      end
      default: ts = SEL_VS;
    endcase
    return ts;
  endfunction

endpackage

// ===== rtl/btps_cfg.sv =====
module btps_cfg
  import btps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  // Register file, one write per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.very_short_ms     <= 16'd50;
      cfg.short_ms          <= 16'd100;
      cfg.pause_short_ms    <= 16'd50;
      cfg.medium_ms         <= 16'd150;
      cfg.long_ms           <= 16'd300;
      cfg.very_long_ms      <= 16'd500;
      cfg.siren_interval_ms <= 16'd250;
      cfg.continuous_note   <= NOTE_MEDIUM;
    end else if (wr_en) begin
      case (wr_index)
        REG_VERY_SHORT: cfg.very_short_ms     <= wr_data;
        REG_SHORT:      cfg.short_ms          <= wr_data;
        REG_PAUSE:      cfg.pause_short_ms    <= wr_data;
        REG_MEDIUM:     cfg.medium_ms         <= wr_data;
        REG_LONG:       cfg.long_ms           <= wr_data;
        REG_VERY_LONG:  cfg.very_long_ms      <= wr_data;
        REG_SIREN:      cfg.siren_interval_ms <= wr_data;
        REG_CONT:       cfg.continuous_note   <= wr_data[3:0];
        default:        cfg.continuous_note   <= cfg.continuous_note;
      endcase
    end
  end

endmodule

// ===== rtl/btps_engine.sv =====
module btps_engine
  import btps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [1:0]  kind,
  input  logic [3:0]  pattern,
  input  logic [31:0] duration_ms,
  input  cfg_t        cfg,
  output result_t     res_next
);

  logic [3:0]  pattern_now, pattern_now_next;
  logic [2:0]  step_now, step_now_next;
  logic        running, running_next;
  logic [31:0] lifetime, lifetime_next;
  logic [31:0] tss, tss_next;
  logic [31:0] tsp, tsp_next;
  logic [3:0]  note_now, note_now_next;

  logic [31:0] tss_inc, tsp_inc;
  logic [2:0]  len;
  logic [2:0]  step_m1;
  time_sel_t   sel;
  logic [15:0] step_time;

  // Saturating counters
  assign tss_inc = (tss == '1) ? tss : tss + 32'd1;
  assign tsp_inc = (tsp == '1) ? tsp : tsp + 32'd1;

  // Step time of the note now sounding
  assign len     = seq_len(pattern_now);
  assign step_m1 = step_now - 3'd1;
  assign sel     = seq_time(pattern_now, step_m1[1:0]);

  always_comb begin
    case (sel)
      SEL_VS:  step_time = cfg.very_short_ms;
      SEL_S:   step_time = cfg.short_ms;
      SEL_P:   step_time = cfg.pause_short_ms;
      SEL_M:   step_time = cfg.medium_ms;
      SEL_L:   step_time = cfg.long_ms;
      SEL_VL:  step_time = cfg.very_long_ms;
      default: step_time = cfg.very_short_ms;
    endcase
  end

  // Next state for one item
  always_comb begin
    pattern_now_next = pattern_now;
    step_now_next    = step_now;
    running_next     = running;
    lifetime_next    = lifetime;
    tss_next         = tss;
    tsp_next         = tsp;
    note_now_next    = note_now;
    case (kind)
      KIND_TICK: begin
        if (running && lifetime != 32'd0) begin
          tss_next = tss_inc;
          tsp_next = tsp_inc;
          if (tss_inc >= lifetime) begin
            running_next  = 1'b0;
            step_now_next = 3'd0;
            lifetime_next = 32'd0;
            note_now_next = NOTE_SILENT;
          end else if (pattern_now < PAT_CONTINUOUS) begin
            if (step_now == 3'd0) begin
              note_now_next = seq_note(pattern_now, 2'd0);
              step_now_next = 3'd1;
              tsp_next      = 32'd0;
            end else if (step_now <= len && step_now <= MAX_NOTES &&
                         tsp_inc >= {16'd0, step_time}) begin
              if (step_now == len) begin
                running_next  = 1'b0;
                step_now_next = 3'd0;
                lifetime_next = 32'd0;
                note_now_next = NOTE_SILENT;
              end else begin
                note_now_next = seq_note(pattern_now, step_now[1:0]);
                step_now_next = step_now + 3'd1;
                tsp_next      = 32'd0;
              end
            end
          end else if (pattern_now == PAT_SIREN) begin
            if (tsp_inc >= {16'd0, cfg.siren_interval_ms}) begin
              if (step_now == 3'd0) begin
                note_now_next = NOTE_HIGH;
                step_now_next = 3'd1;
              end else begin
                note_now_next = NOTE_MEDIUM;
                step_now_next = 3'd0;
              end
              tsp_next = 32'd0;
            end
          end
        end
      end
      KIND_START: begin
        pattern_now_next = pattern;
        lifetime_next    = duration_ms;
        step_now_next    = 3'd0;
        tss_next         = 32'd0;
        tsp_next         = 32'd0;
        running_next     = 1'b1;
        if (pattern == PAT_CONTINUOUS) begin
          note_now_next = cfg.continuous_note;
        end else if (pattern == PAT_SIREN) begin
          note_now_next = NOTE_MEDIUM;
        end else begin
          note_now_next = NOTE_SILENT;
        end
      end
      KIND_STOP: begin
        running_next  = 1'b0;
        step_now_next = 3'd0;
        lifetime_next = 32'd0;
        note_now_next = NOTE_SILENT;
      end
      default: begin
        note_now_next = note_now;
      end
    endcase
  end

  assign res_next.note   = note_now_next;
  assign res_next.active = running_next;
  assign res_next.step   = step_now_next;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_now <= 4'd0;
      step_now    <= 3'd0;
      running     <= 1'b0;
      lifetime    <= 32'd0;
      tss         <= 32'd0;
      tsp         <= 32'd0;
      note_now    <= NOTE_SILENT;
    end else if (en) begin
      pattern_now <= pattern_now_next;
      step_now    <= step_now_next;
      running     <= running_next;
      lifetime    <= lifetime_next;
      tss         <= tss_next;
      tsp         <= tsp_next;
      note_now    <= note_now_next;
    end
  end

endmodule

// ===== rtl/buzzer_tone_pattern_sequencer.sv =====
// Buzzer tone pattern sequencer.
// Input stream (s_*): tuser carries the item kind (tick, start, stop); tdata
// carries pattern and duration for a start. Each accepted item gives exactly
// one output item (m_*) with the sounding note code, the active flag and the
// step number after that item's update.
// Configuration: cfg_valid/cfg_index/cfg_data write one step-time or note
// register; cfg_ready is always high. Write only while no item is in flight.
// Path: an accepted item passes through the input register, then the result
// register, before it is presented on m_*.
// Throughput: one item per cycle while m_tready is high; the state update is a
// single pass of compares and saturating increments between the two registers.
// Stall: while a result waits with m_tready low the result register holds; one
// more item waits in the input register and s_tready then drops until the result
// is taken.
// Reset (rst, synchronous): pipeline emptied, sequencer idle and silent,
// counters cleared and the configuration back to its defaults.
`include "assert_macros.svh"

module buzzer_tone_pattern_sequencer
  import btps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] pattern, [35:4] duration_ms, [39:36] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [3:0] note, [4] active, [7:5] step
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  result_t     res_next;
  logic        in_valid;
  logic [1:0]  in_kind;
  logic [3:0]  in_pattern;
  logic [31:0] in_duration;
  logic        advance;

  assign cfg_ready = 1'b1;

  btps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Item moves from input register into the result register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind     <= s_tuser;
      in_pattern  <= s_tdata[3:0];
      in_duration <= s_tdata[35:4];
    end
  end

  btps_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .kind        (in_kind),
    .pattern     (in_pattern),
    .duration_ms (in_duration),
    .cfg         (cfg),
    .res_next    (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= res_next;
    end
  end

  // An idle sequencer always reports step zero
  `ASSERT_ALWAYS(a_idle_step_zero, clk, rst, !m_tvalid || m_tdata[4] || m_tdata[7:5] == 3'd0)
  // Step never runs past the longest pattern
  `ASSERT_ALWAYS(a_step_range, clk, rst, !m_tvalid || m_tdata[7:5] <= MAX_NOTES)
  // Input side only backs up when a result is waiting
  `ASSERT_ALWAYS(a_stall_cause, clk, rst, s_tready || m_tvalid)
  // An item that advances is visible on the output in the next cycle
  `ASSERT_NEXT(a_advance_out, clk, rst, advance, m_tvalid)

endmodule

// ===== tb/buzzer_tone_pattern_sequencer_checker.sv =====
`timescale 1ns / 100ps

// Watches the item, output and register channels of the sequencer, keeps its
// own copy of the sequencer state and checks every output item in order.
module buzzer_tone_pattern_sequencer_checker
  import btps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [3:0] pattern, [35:4] duration_ms, [39:36] zero
  input  logic [1:0]  s_tuser,   // [1:0] kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [3:0] note, [4] active, [7:5] step
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  // Register copy
  logic [15:0] step_ms [0:6];
  logic [3:0]  cont_note;

  // Sequencer state copy
  logic [3:0]  pattern_now;
  logic [2:0]  step_now;
  logic        playing;
  logic [31:0] lifetime;
  logic [31:0] since_start;
  logic [31:0] since_step;
  logic [3:0]  note_now;

  // Output items predicted, oldest first
  result_t predicted_notes [$];

  // Notes in a stepped pattern
  function automatic logic [2:0] notes_in(input logic [3:0] pat);
    case (pat)
      4'd0, 4'd5:       return 3'd1;
      4'd2, 4'd8:       return 3'd2;
      4'd1, 4'd3, 4'd6: return 3'd3;
      4'd4, 4'd7:       return 3'd4;
      default:          return 3'd0;
    endcase
  endfunction

  // Note at position idx; rows list position 3 down to position 0
  function automatic logic [3:0] note_at(input logic [3:0] pat, input logic [1:0] idx);
    logic [15:0] row;
    case (pat)
      4'd0:    row = {NOTE_SILENT, NOTE_SILENT, NOTE_SILENT, NOTE_E5};
      4'd1:    row = {NOTE_SILENT, NOTE_E5, NOTE_SILENT, NOTE_C5};
      4'd2:    row = {NOTE_SILENT, NOTE_SILENT, NOTE_E5, NOTE_C5};
      4'd3:    row = {NOTE_SILENT, NOTE_G5, NOTE_E5, NOTE_C5};
      4'd4:    row = {NOTE_C6, NOTE_G5, NOTE_E5, NOTE_C5};
      4'd5:    row = {NOTE_SILENT, NOTE_SILENT, NOTE_SILENT, NOTE_LOW};
      4'd6:    row = {NOTE_SILENT, NOTE_LOW, NOTE_MEDIUM, NOTE_HIGH};
      4'd7:    row = {NOTE_C4, NOTE_G4, NOTE_C5, NOTE_E5};
      4'd8:    row = {NOTE_SILENT, NOTE_SILENT, NOTE_C5, NOTE_G4};
      default: row = '0;
    endcase
    return row[idx * 4 +: 4];
  endfunction

  // Ticks that the note at position idx holds, from the step-time registers
  function automatic logic [31:0] hold_ticks(input logic [3:0] pat, input logic [1:0] idx);
    logic [11:0] row;
    case (pat)
      4'd1:       row = {REG_VERY_SHORT, REG_SHORT, REG_PAUSE, REG_SHORT};
      4'd2, 4'd8: row = {REG_VERY_SHORT, REG_VERY_SHORT, REG_SHORT, REG_VERY_SHORT};
      4'd3:       row = {REG_VERY_SHORT, REG_LONG, REG_MEDIUM, REG_MEDIUM};
      4'd4, 4'd7: row = {REG_VERY_LONG, REG_MEDIUM, REG_MEDIUM, REG_MEDIUM};
      4'd6:       row = {REG_VERY_SHORT, REG_MEDIUM, REG_VERY_SHORT, REG_VERY_SHORT};
      default:    row = {4{REG_VERY_SHORT}};
    endcase
    return {16'd0, step_ms[row[idx * 3 +: 3]]};
  endfunction

  // Stop by command, expiry or end of pattern; counters keep their values
  task automatic silence();
    playing  = 1'b0;
    step_now = 3'd0;
    lifetime = 32'd0;
    note_now = NOTE_SILENT;
  endtask

  // Advance the state copy by one item and queue the output item it gives
  task automatic sequence_item(input logic [1:0] kind, input logic [3:0] pat,
                               input logic [31:0] dur);
    result_t r;
    case (kind)
      KIND_TICK: begin
        if (playing && lifetime != 32'd0) begin
          if (since_start != '1) since_start = since_start + 32'd1;
          if (since_step != '1) since_step = since_step + 32'd1;
          if (since_start >= lifetime) begin
            silence();
          end else if (pattern_now < PAT_CONTINUOUS) begin
            if (step_now == 3'd0) begin
              note_now   = note_at(pattern_now, 2'd0);
              step_now   = 3'd1;
              since_step = 32'd0;
            end else if (step_now <= notes_in(pattern_now) && step_now <= MAX_NOTES &&
                         since_step >= hold_ticks(pattern_now, 2'(step_now - 3'd1))) begin
              if (step_now == notes_in(pattern_now)) begin
                silence();
              end else begin
                note_now   = note_at(pattern_now, step_now[1:0]);
                step_now   = step_now + 3'd1;
                since_step = 32'd0;
              end
            end
          end else if (pattern_now == PAT_SIREN) begin
            if (since_step >= {16'd0, step_ms[REG_SIREN]}) begin
              // siren toggles between the high and medium notes
              if (step_now == 3'd0) begin
                note_now = NOTE_HIGH;
                step_now = 3'd1;
              end else begin
                note_now = NOTE_MEDIUM;
                step_now = 3'd0;
              end
              since_step = 32'd0;
            end
          end
        end
      end
      KIND_START: begin
        pattern_now = pat;
        lifetime    = dur;
        step_now    = 3'd0;
        since_start = 32'd0;
        since_step  = 32'd0;
        playing     = 1'b1;
        if (pat == PAT_CONTINUOUS) note_now = cont_note;
        else if (pat == PAT_SIREN) note_now = NOTE_MEDIUM;
        else note_now = NOTE_SILENT;
      end
      KIND_STOP: silence();
      default: ;
    endcase
    r.note   = note_now;
    r.active = playing;
    r.step   = step_now;
    predicted_notes.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t mismatch: %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t due;
    if (rst) begin
      predicted_notes.delete();
      step_ms[REG_VERY_SHORT] = 16'd50;
      step_ms[REG_SHORT]      = 16'd100;
      step_ms[REG_PAUSE]      = 16'd50;
      step_ms[REG_MEDIUM]     = 16'd150;
      step_ms[REG_LONG]       = 16'd300;
      step_ms[REG_VERY_LONG]  = 16'd500;
      step_ms[REG_SIREN]      = 16'd250;
      cont_note   = NOTE_MEDIUM;
      pattern_now = 4'd0;
      step_now    = 3'd0;
      playing     = 1'b0;
      lifetime    = 32'd0;
      since_start = 32'd0;
      since_step  = 32'd0;
      note_now    = NOTE_SILENT;
      mismatches  = 0;
      pending     = 0;
      checked     = 0;
    end else begin
      // compare before queuing: an output item never belongs to this edge's input
      if (m_tvalid && m_tready) begin
        seen = result_t'(m_tdata);
        if (predicted_notes.size() == 0) begin
          report_mismatch($sformatf("output item %h with none predicted", m_tdata));
        end else begin
          due = predicted_notes.pop_front();
          if (seen.note !== due.note)
            report_mismatch($sformatf("note %0d, predicted %0d", seen.note, due.note));
          if (seen.active !== due.active)
            report_mismatch($sformatf("active %0b, predicted %0b", seen.active, due.active));
          if (seen.step !== due.step)
            report_mismatch($sformatf("step %0d, predicted %0d", seen.step, due.step));
          checked = checked + 1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CONT) cont_note = cfg_data[3:0];
        else step_ms[cfg_index] = cfg_data;
      end
      if (s_tvalid && s_tready) sequence_item(s_tuser, s_tdata[3:0], s_tdata[35:4]);
      pending = predicted_notes.size();
    end
  end

endmodule

// ===== tb/buzzer_tone_pattern_sequencer_tb.sv =====
`timescale 1ns / 100ps

module buzzer_tone_pattern_sequencer_tb;
  import btps_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 270;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [3:0] pattern, [35:4] duration_ms, [39:36] zero
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [3:0] note, [4] active, [7:5] step
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int pending;
  int checked;
  int src_idle_pct = 15;
  int sink_idle_pct = 65;
  int n_items = 0;
  int kind_count [0:3] = '{0, 0, 0, 0};
  int cycle_count = 0;

  buzzer_tone_pattern_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  buzzer_tone_pattern_sequencer_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("buzzer_tone_pattern_sequencer_tb failed");
      $finish;
    end
  end

  // One item on the input channel, with random sender gaps
  task automatic send_item(input logic [1:0] kind, input logic [3:0] pat,
                           input logic [31:0] dur);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'd0, dur, pat};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    n_items = n_items + 1;
    kind_count[kind] = kind_count[kind] + 1;
  endtask

  // Drop valid and wait for every predicted output item
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Write all eight registers for one setting
  task automatic write_config(input int setting);
    logic [15:0] val;
    logic [3:0]  nt;
    for (int i = 0; i < 8; i++) begin
      if (i == REG_CONT) begin
        case (setting)
          0:       nt = 4'($urandom_range(9, 1));
          1:       nt = 4'($urandom_range(15, 10));
          2:       nt = 4'd0;
          3:       nt = 4'd15;
          4:       nt = NOTE_C4;
          default: nt = 4'($urandom_range(15, 0));
        endcase
        // upper bits are don't-care for the note register
        val = {12'($urandom), nt};
      end else begin
        case (setting)
          0:       val = 16'($urandom_range(6, 1));
          1:       val = 16'($urandom_range(1, 0));
          2:       val = 16'($urandom_range(10, 0));
          3:       val = (i % 2 == 1 || i == REG_SIREN) ? 16'hFFFF : 16'($urandom_range(4, 1));
          4:       val = 16'd1;
          default: val = 16'($urandom_range(12, 0));
        endcase
      end
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // A start followed by a run of ticks, with the odd stop or unused kind;
  // some phrases are a single random item instead
  task automatic play_phrase();
    int r;
    int ticks;
    logic [3:0]  pat;
    logic [31:0] dur;
    r = $urandom_range(99);
    if (r < 10) begin
      send_item(2'($urandom_range(3)), 4'($urandom), $urandom);
      return;
    end
    pat = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
    r = $urandom_range(99);
    if (r < 8) dur = 32'd0;
    else if (r < 16) dur = $urandom;
    else if (r < 20) dur = '1;
    else dur = $urandom_range(80, 1);
    send_item(KIND_START, pat, dur);
    ticks = $urandom_range(60, 1);
    repeat (ticks) begin
      r = $urandom_range(99);
      if (r < 3) send_item(KIND_STOP, 4'($urandom), $urandom);
      else if (r < 5) send_item(KIND_UNUSED, 4'($urandom), $urandom);
      else send_item(KIND_TICK, 4'($urandom), $urandom);
    end
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items at the reset register values
    send_item(KIND_TICK, 4'd0, 32'd0);              // tick while idle
    send_item(KIND_UNUSED, 4'hF, '1);               // unused kind
    send_item(KIND_STOP, 4'd0, 32'd0);              // stop while idle
    send_item(KIND_START, 4'd15, 32'd0);            // unused pattern, frozen
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_START, PAT_CONTINUOUS, '1);      // continuous, longest lifetime
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_STOP, 4'd0, 32'd0);
    send_item(KIND_START, PAT_SIREN, 32'd1);        // expires on first tick
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_START, 4'd4, 32'd3);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_START, 4'd0, '1);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_START, 4'd1, 32'd5);
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_START, PAT_SIREN, 32'd0);        // frozen siren
    send_item(KIND_TICK, 4'd0, 32'd0);
    send_item(KIND_STOP, 4'd0, 32'd0);
    wait_drained();

    // Random phases: two register settings per flow-control mode
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          src_idle_pct  = 15;
          sink_idle_pct = 65;
        end
        1: begin
          src_idle_pct  = 65;
          sink_idle_pct = 15;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      write_config(ph);
      target = n_items + PHASE_ITEMS;
      while (n_items < target) play_phrase();
      wait_drained();
    end

    repeat (4) @(negedge clk);
    $display("Sent %0d items: %0d ticks, %0d starts, %0d stops, %0d of the unused kind",
             n_items, kind_count[KIND_TICK], kind_count[KIND_START],
             kind_count[KIND_STOP], kind_count[KIND_UNUSED]);
    $display("Checked %0d output items under reset values and six register settings",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("buzzer_tone_pattern_sequencer_tb passed");
    end else begin
      $display("buzzer_tone_pattern_sequencer_tb failed");
    end
    $finish;
  end

endmodule
